// File: src/psg_env_pkg.sv
`timescale 1ns / 1ps

package psg_env_pkg;

    // Field and register widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PERIOD_W = 2 * BYTE_W;
    localparam int unsigned SHAPE_W  = 4;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned CLK_W    = 25;
    localparam int unsigned RATE_W   = 18;
    localparam int unsigned SPF_W    = 12;
    localparam int unsigned CFG_W    = CLK_W;
    localparam int unsigned CFG_IDX_W = 2;

    // Step arithmetic
    localparam int unsigned STEP_SHIFT = 23;
    localparam int unsigned NUM_W      = CLK_W + STEP_SHIFT;
    localparam int unsigned DEN_W      = PERIOD_W + RATE_W;
    localparam int unsigned PROD_W     = POS_W + SPF_W;
    localparam int unsigned SUM_W      = PROD_W + 1;
    localparam int unsigned DIV_STEPS  = NUM_W;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(3);

    // Level lookup
    localparam int unsigned LEVEL_SHIFT = 27;
    localparam logic [BYTE_W-1:0]  NO_SHAPE_WRITE = 8'hff;
    localparam logic [SHAPE_W-1:0] FIXED_SHAPE    = 4'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHIP_CLK         = 2'd0,
        REG_SAMPLE_RATE      = 2'd1,
        REG_FRAME_LEN        = 2'd2,
        REG_FIXED_SHAPE_MODE = 2'd3
    } cfg_reg_t;

    localparam logic [CLK_W-1:0]  RST_CHIP_CLK    = CLK_W'(2000000);
    localparam logic [RATE_W-1:0] RST_SAMPLE_RATE = RATE_W'(44100);
    localparam logic [SPF_W-1:0]  RST_FRAME_LEN   = SPF_W'(882);

    // Ramp segments: {start, end}. 2'b10 falls, 2'b01 rises, 2'b11 holds high.
    typedef logic [1:0] seg_t;
    localparam seg_t WAVE_SEG [16][4] = '{
        '{2'b10, 2'b00, 2'b00, 2'b00}, '{2'b10, 2'b00, 2'b00, 2'b00},
        '{2'b10, 2'b00, 2'b00, 2'b00}, '{2'b10, 2'b00, 2'b00, 2'b00},
        '{2'b01, 2'b00, 2'b00, 2'b00}, '{2'b01, 2'b00, 2'b00, 2'b00},
        '{2'b01, 2'b00, 2'b00, 2'b00}, '{2'b01, 2'b00, 2'b00, 2'b00},
        '{2'b10, 2'b10, 2'b10, 2'b10}, '{2'b10, 2'b00, 2'b00, 2'b00},
        '{2'b10, 2'b01, 2'b10, 2'b01}, '{2'b10, 2'b11, 2'b11, 2'b11},
        '{2'b01, 2'b01, 2'b01, 2'b01}, '{2'b01, 2'b11, 2'b11, 2'b11},
        '{2'b01, 2'b10, 2'b01, 2'b10}, '{2'b01, 2'b00, 2'b00, 2'b00}
    };

    // Microprogram
    localparam int unsigned PC_W = 3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETUP,
        OP_DIV,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WAIT_OUT,
        COND_LOOP,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            cnt_load;
    } ctrl_word_t;

    typedef struct packed {
        op_t  op;
        logic en;
        logic in_ready;
    } seq_ctrl_t;

    localparam logic [PC_W-1:0] PC_LOAD = 3'd0;
    localparam logic [PC_W-1:0] PC_DIV  = 3'd2;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd4;

    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            3'd0: w = '{op: OP_LOAD,  cond: COND_WAIT_IN,  target: PC_LOAD, cnt_load: 1'b0};
            3'd1: w = '{op: OP_SETUP, cond: COND_NEXT,     target: PC_LOAD, cnt_load: 1'b1};
            3'd2: w = '{op: OP_DIV,   cond: COND_LOOP,     target: PC_DIV,  cnt_load: 1'b0};
            3'd3: w = '{op: OP_MUL,   cond: COND_NEXT,     target: PC_LOAD, cnt_load: 1'b0};
            3'd4: w = '{op: OP_EMIT,  cond: COND_WAIT_OUT, target: PC_EMIT, cnt_load: 1'b0};
            default: w = '{op: OP_NOP, cond: COND_JUMP,    target: PC_LOAD, cnt_load: 1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [LEVEL_W-1:0] env_level(
        input logic [SHAPE_W-1:0] shape,
        input logic               phase,
        input logic [POS_W-1:0]   pos
    );
        logic [4:0]         idx;
        logic [1:0]         seg;
        seg_t               ab;
        logic [LEVEL_W-1:0] lvl;
        idx = pos[LEVEL_SHIFT +: 5];
        seg = {phase, idx[4]};
        ab  = WAVE_SEG[shape][seg];
        case (ab)
            2'b11:   lvl = 4'hf;
            2'b10:   lvl = ~idx[3:0];
            2'b01:   lvl = idx[3:0];
            default: lvl = 4'h0;
        endcase
        return lvl;
    endfunction

endpackage

// File: src/psg_env_seq.sv
`timescale 1ns / 1ps

module psg_env_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_full,
    output psg_env_pkg::seq_ctrl_t ctrl
);

    logic [psg_env_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [psg_env_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    psg_env_pkg::ctrl_word_t       word;
    logic                          en;

    always_comb begin
        word     = psg_env_pkg::rom_word(pc_reg);
        pc_next  = pc_reg + 1'b1;
        cnt_next = cnt_reg;
        en       = 1'b1;
        case (word.cond)
            psg_env_pkg::COND_WAIT_IN: begin
                if (!in_valid) begin
                    en      = 1'b0;
                    pc_next = word.target;
                end
            end
            psg_env_pkg::COND_WAIT_OUT: begin
                if (out_full) begin
                    en      = 1'b0;
                    pc_next = word.target;
                end
            end
            psg_env_pkg::COND_LOOP: begin
                if (cnt_reg != '0) begin
                    pc_next  = word.target;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            psg_env_pkg::COND_JUMP: begin
                pc_next = word.target;
            end
            default: begin
            end
        endcase
        if (word.cnt_load && en) begin
            cnt_next = psg_env_pkg::DIV_LAST;
        end
        ctrl.op       = word.op;
        ctrl.en       = en;
        ctrl.in_ready = (word.cond == psg_env_pkg::COND_WAIT_IN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= psg_env_pkg::PC_LOAD;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: src/psg_env_dp.sv
`timescale 1ns / 1ps

module psg_env_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  psg_env_pkg::seq_ctrl_t              ctrl,
    input  logic [psg_env_pkg::CLK_W-1:0]       chip_clk_hz,
    input  logic [psg_env_pkg::RATE_W-1:0]      sample_rate,
    input  logic [psg_env_pkg::SPF_W-1:0]       frame_len,
    input  logic                                fixed_shape_mode,
    input  logic [psg_env_pkg::BYTE_W-1:0]      period_low,
    input  logic [psg_env_pkg::BYTE_W-1:0]      period_high,
    input  logic [psg_env_pkg::BYTE_W-1:0]      shape_byte,
    output logic [psg_env_pkg::LEVEL_W-1:0]     env_level
);

    // Frame payload
    logic [psg_env_pkg::PERIOD_W-1:0] per_reg, per_next;
    logic                             wr_reg, wr_next;
    logic [psg_env_pkg::SHAPE_W-1:0]  new_shape_reg, new_shape_next;

    // Division and product
    logic [psg_env_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [psg_env_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [psg_env_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [psg_env_pkg::PROD_W-1:0] prod_reg, prod_next;

    // Envelope state
    logic [psg_env_pkg::SHAPE_W-1:0] shape_reg, shape_next;
    logic                            phase_reg, phase_next;
    logic [psg_env_pkg::POS_W-1:0]   pos_reg, pos_next;

    logic                            shape_wr;
    logic [psg_env_pkg::DEN_W:0]     trial;
    logic                            ge;
    logic [psg_env_pkg::POS_W-1:0]   step;
    logic [psg_env_pkg::SUM_W-1:0]   sum;

    always_comb begin
        per_next       = per_reg;
        wr_next        = wr_reg;
        new_shape_next = new_shape_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        prod_next      = prod_reg;
        shape_next     = shape_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;

        shape_wr = (shape_byte != psg_env_pkg::NO_SHAPE_WRITE);
        trial    = {rem_reg, quo_reg[psg_env_pkg::NUM_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        step     = (per_reg < psg_env_pkg::MIN_PERIOD) ? '0
                                                       : quo_reg[psg_env_pkg::POS_W-1:0];
        sum      = psg_env_pkg::SUM_W'(pos_reg) + psg_env_pkg::SUM_W'(prod_reg);

        if (ctrl.en) begin
            case (ctrl.op)
                psg_env_pkg::OP_LOAD: begin
                    wr_next = shape_wr;
                    if (shape_wr && fixed_shape_mode) begin
                        per_next       = {{psg_env_pkg::BYTE_W{1'b0}}, period_low};
                        new_shape_next = psg_env_pkg::FIXED_SHAPE;
                    end else begin
                        per_next       = {period_high, period_low};
                        new_shape_next = shape_byte[psg_env_pkg::SHAPE_W-1:0];
                    end
                end
                psg_env_pkg::OP_SETUP: begin
                    den_next = psg_env_pkg::DEN_W'(per_reg) * psg_env_pkg::DEN_W'(sample_rate);
                    rem_next = '0;
                    quo_next = {chip_clk_hz, {psg_env_pkg::STEP_SHIFT{1'b0}}};
                    if (wr_reg) begin
                        shape_next = new_shape_reg;
                        phase_next = 1'b0;
                        pos_next   = '0;
                    end
                end
                psg_env_pkg::OP_DIV: begin
                    // One restoring step: a zero divisor yields all ones.
                    rem_next = ge ? psg_env_pkg::DEN_W'(trial - {1'b0, den_reg})
                                  : trial[psg_env_pkg::DEN_W-1:0];
                    quo_next = {quo_reg[psg_env_pkg::NUM_W-2:0], ge};
                end
                psg_env_pkg::OP_MUL: begin
                    prod_next = psg_env_pkg::PROD_W'(step) * psg_env_pkg::PROD_W'(frame_len);
                end
                psg_env_pkg::OP_EMIT: begin
                    pos_next = sum[psg_env_pkg::POS_W-1:0];
                    if (sum[psg_env_pkg::SUM_W-1:psg_env_pkg::POS_W] != '0) begin
                        phase_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        env_level = psg_env_pkg::env_level(shape_reg, phase_reg, pos_reg);
    end

    always_ff @(posedge aclk) begin
        per_reg       <= per_next;
        wr_reg        <= wr_next;
        new_shape_reg <= new_shape_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        prod_reg      <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= '0;
            phase_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            shape_reg <= shape_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: src/psg_envelope_generator_top.sv
`timescale 1ns / 1ps

// Envelope generator of a programmable sound generator, stepped once per player frame.
// Input channel (s_): one beat per frame carrying the envelope period bytes and the shape
// byte, where 0xFF means that the frame writes no shape. Result channel (m_): one beat per
// frame carrying the 0..15 envelope level after the frame's shape write and before the
// frame's advance. Both channels use valid/ready; a beat moves when both are high.
// The work is run by a small microprogram: load, set-up, 48 restoring division steps for
// the phase step, one multiply by samples per frame, then emit and advance. The input is
// ready only at the load step, so a new frame is taken only once the last one has passed
// the emit step and the jump step back to load. The result sits in an output register, so
// a further frame is accepted and worked on while an earlier result still waits; if the
// receiver stalls, the sequencer holds at the emit step until the register is free, and
// nothing is lost. Reset (aresetn, synchronous, active low) restores the default
// configuration, clears the shape, phase and position, and drops m_valid. Configuration
// is written through cfg_wr_en, cfg_index and cfg_wdata, one register per cycle; the user
// must write it only while the block is idle, which the block itself does not enforce.
module psg_envelope_generator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [psg_env_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psg_env_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [psg_env_pkg::BYTE_W-1:0]       s_period_low,
    input  logic [psg_env_pkg::BYTE_W-1:0]       s_period_high,
    input  logic [psg_env_pkg::BYTE_W-1:0]       s_shape_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [psg_env_pkg::LEVEL_W-1:0]      m_env_level
);

    // Configuration registers
    logic [psg_env_pkg::CLK_W-1:0]  chip_clk_reg, chip_clk_next;
    logic [psg_env_pkg::RATE_W-1:0] sample_rate_reg, sample_rate_next;
    logic [psg_env_pkg::SPF_W-1:0]  spf_reg, spf_next;
    logic                           fixed_shape_reg, fixed_shape_next;

    // Output register
    logic                              m_valid_reg, m_valid_next;
    logic [psg_env_pkg::LEVEL_W-1:0]   m_level_reg, m_level_next;

    psg_env_pkg::seq_ctrl_t           ctrl;
    logic [psg_env_pkg::LEVEL_W-1:0]  level;
    logic                             out_full;
    logic                             emit_fire;

    // The slot counts as free when its current beat is being taken this cycle.
    assign out_full  = m_valid_reg && !m_ready;
    assign emit_fire = ctrl.en && (ctrl.op == psg_env_pkg::OP_EMIT);

    assign s_ready     = ctrl.in_ready;
    assign m_valid     = m_valid_reg;
    assign m_env_level = m_level_reg;

    always_comb begin
        chip_clk_next    = chip_clk_reg;
        sample_rate_next = sample_rate_reg;
        spf_next         = spf_reg;
        fixed_shape_next = fixed_shape_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                psg_env_pkg::REG_CHIP_CLK:
                    chip_clk_next = cfg_wdata[psg_env_pkg::CLK_W-1:0];
                psg_env_pkg::REG_SAMPLE_RATE:
                    sample_rate_next = cfg_wdata[psg_env_pkg::RATE_W-1:0];
                psg_env_pkg::REG_FRAME_LEN:
                    spf_next = cfg_wdata[psg_env_pkg::SPF_W-1:0];
                psg_env_pkg::REG_FIXED_SHAPE_MODE:
                    fixed_shape_next = cfg_wdata[0];
                default: begin
                end
            endcase
        end

        m_valid_next = m_valid_reg;
        m_level_next = m_level_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
            m_level_next = level;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_clk_reg    <= psg_env_pkg::RST_CHIP_CLK;
            sample_rate_reg <= psg_env_pkg::RST_SAMPLE_RATE;
            spf_reg         <= psg_env_pkg::RST_FRAME_LEN;
            fixed_shape_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            chip_clk_reg    <= chip_clk_next;
            sample_rate_reg <= sample_rate_next;
            spf_reg         <= spf_next;
            fixed_shape_reg <= fixed_shape_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_level_reg <= m_level_next;
    end

    psg_env_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_full (out_full),
        .ctrl     (ctrl)
    );

    psg_env_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .chip_clk_hz       (chip_clk_reg),
        .sample_rate       (sample_rate_reg),
        .frame_len         (spf_reg),
        .fixed_shape_mode  (fixed_shape_reg),
        .period_low        (s_period_low),
        .period_high       (s_period_high),
        .shape_byte        (s_shape_byte),
        .env_level         (level)
    );

    // A result is only written into a free output slot.
    assert property (@(posedge aclk) disable iff (!aresetn) emit_fire |-> !out_full)
        else $error("result emitted into an occupied output register");

    // The sequencer never offers to take a frame in the cycle it emits one.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && emit_fire))
        else $error("input ready while emitting a result");

    // Once a frame is taken the input closes until the frame has been worked through.
    assert property (@(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after an accept");

    // After the emit step the sequencer passes the jump step and then returns to the load step.
    assert property (@(posedge aclk) disable iff (!aresetn) emit_fire |=> ##1 s_ready)
        else $error("sequencer did not return to the load step after emitting");

endmodule
